@@ rtl/core/srfd_pkg.sv @@
// shared types and constants of the sensor response frame decoder
// no dependencies; imported by the interfaces and all rtl/core modules
package srfd_pkg;

  localparam int LEN_W      = 7;   // width of a frame length register
  localparam int CFG_IDX_W  = 3;
  localparam int KEPT_BYTES = 17;  // buffer positions that a reading can come from

  localparam logic [7:0] ADDR_CO2      = 8'h01;
  localparam logic [7:0] ADDR_PRESSURE = 8'h02;
  localparam logic [7:0] ADDR_PH       = 8'h04;
  localparam logic [7:0] ADDR_LIGHT    = 8'h05;
  localparam logic [7:0] ADDR_SOIL     = 8'h06;

  localparam logic [CFG_IDX_W-1:0] CFG_CO2_LEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOIL_LEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PH_LEN       = 3'd4;

  localparam logic [LEN_W-1:0] CO2_LEN_RST      = 7'd11;
  localparam logic [LEN_W-1:0] PRESSURE_LEN_RST = 7'd9;
  localparam logic [LEN_W-1:0] LIGHT_LEN_RST    = 7'd19;
  localparam logic [LEN_W-1:0] SOIL_LEN_RST     = 7'd11;
  localparam logic [LEN_W-1:0] PH_LEN_RST       = 7'd7;

  typedef enum logic [2:0] {
    KIND_CO2      = 3'd0,
    KIND_PRESSURE = 3'd1,
    KIND_LIGHT    = 3'd2,
    KIND_SOIL     = 3'd3,
    KIND_PH       = 3'd4
  } frame_kind_t;

  typedef struct packed {
    logic [LEN_W-1:0] co2_len;
    logic [LEN_W-1:0] pressure_len;
    logic [LEN_W-1:0] light_len;
    logic [LEN_W-1:0] soil_len;
    logic [LEN_W-1:0] ph_len;
  } srfd_cfg_t;

  typedef struct packed {
    frame_kind_t frame_kind;
    logic [15:0] co2_level;
    logic [15:0] air_humidity_value;
    logic [15:0] air_pressure_value;
    logic [15:0] air_temperature_value;
    logic [15:0] light_level;
    logic [15:0] soil_temperature_value;
    logic [15:0] soil_water_value;
    logic [15:0] soil_conductivity_value;
    logic [14:0] soil_salt_value;
    logic [7:0]  ph_value;
  } srfd_result_t;

  typedef struct packed {
    logic hit;        // the byte under decode completes a frame
    logic cnt_zero;   // stored byte count is zero
  } srfd_status_t;

endpackage

@@ rtl/core/srfd_if.sv @@
// valid/ready channels of the decoder: received bytes in, decoded results out
// depends on srfd_pkg
interface srfd_byte_if import srfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srfd_result_if import srfd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  frame_kind;
  logic [15:0] co2_level;
  logic [15:0] air_humidity_value;
  logic [15:0] air_pressure_value;
  logic [15:0] air_temperature_value;
  logic [15:0] light_level;
  logic [15:0] soil_temperature_value;
  logic [15:0] soil_water_value;
  logic [15:0] soil_conductivity_value;
  logic [14:0] soil_salt_value;
  logic [7:0]  ph_value;

  modport source (output valid, output frame_kind, output co2_level,
                  output air_humidity_value, output air_pressure_value,
                  output air_temperature_value, output light_level,
                  output soil_temperature_value, output soil_water_value,
                  output soil_conductivity_value, output soil_salt_value,
                  output ph_value, input ready);
  modport sink   (input valid, input frame_kind, input co2_level,
                  input air_humidity_value, input air_pressure_value,
                  input air_temperature_value, input light_level,
                  input soil_temperature_value, input soil_water_value,
                  input soil_conductivity_value, input soil_salt_value,
                  input ph_value, output ready);
endinterface

@@ rtl/core/srfd_frame_parser.sv @@
// frame store, byte count, address and length match, held readings
// depends on srfd_pkg
module srfd_frame_parser import srfd_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [7:0]   rx_byte,
  input  srfd_cfg_t    cfg,
  output srfd_result_t result,
  output srfd_status_t status
);

  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;

  logic [CW-1:0]    byte_count;
  logic [CW-1:0]    count_inc;
  logic [CW-1:0]    count_next;
  logic             not_full;
  logic [7:0]       frame_buffer [KEPT_BYTES];
  logic [7:0]       view [KEPT_BYTES];
  logic [7:0]       head;
  logic             head_ok;
  logic             match;
  logic [LEN_W-1:0] len_sel;
  frame_kind_t      kind;

  logic [15:0] held_co2, held_co2_next;
  logic [15:0] held_humidity, held_humidity_next;
  logic [15:0] held_pressure, held_pressure_next;
  logic [15:0] held_air_temperature, held_air_temperature_next;
  logic [15:0] held_light, held_light_next;
  logic [15:0] held_soil_temperature, held_soil_temperature_next;
  logic [15:0] held_soil_water, held_soil_water_next;
  logic [15:0] held_soil_conductivity, held_soil_conductivity_next;
  logic [14:0] held_salt, held_salt_next;
  logic [7:0]  held_ph, held_ph_next;

  assign not_full  = byte_count < CW'(BUFFER_BYTES);
  assign count_inc = not_full ? byte_count + 1'b1 : byte_count;

  // buffer contents as seen after this byte is stored
  always_comb begin
    for (int i = 0; i < KEPT_BYTES; i++) begin
      view[i] = (byte_count == CW'(i)) ? rx_byte : frame_buffer[i];
    end
  end

  assign head = view[0];

  always_comb begin
    head_ok = 1'b1;
    len_sel = cfg.co2_len;
    kind    = KIND_CO2;
    unique case (head)
      ADDR_CO2: begin
        len_sel = cfg.co2_len;
        kind    = KIND_CO2;
      end
      ADDR_PRESSURE: begin
        len_sel = cfg.pressure_len;
        kind    = KIND_PRESSURE;
      end
      ADDR_LIGHT: begin
        len_sel = cfg.light_len;
        kind    = KIND_LIGHT;
      end
      ADDR_SOIL: begin
        len_sel = cfg.soil_len;
        kind    = KIND_SOIL;
      end
      ADDR_PH: begin
        len_sel = cfg.ph_len;
        kind    = KIND_PH;
      end
      default: head_ok = 1'b0;
    endcase
  end

  assign match      = head_ok && (LW'(count_inc) == LW'(len_sel));
  assign count_next = (!head_ok || match) ? '0 : count_inc;

  always_comb begin
    held_co2_next               = held_co2;
    held_humidity_next          = held_humidity;
    held_pressure_next          = held_pressure;
    held_air_temperature_next   = held_air_temperature;
    held_light_next             = held_light;
    held_soil_temperature_next  = held_soil_temperature;
    held_soil_water_next        = held_soil_water;
    held_soil_conductivity_next = held_soil_conductivity;
    held_salt_next              = held_salt;
    held_ph_next                = held_ph;
    if (match) begin
      case (kind)
        KIND_CO2: begin
          held_co2_next      = {view[7], view[8]};
          held_humidity_next = {view[3], view[4]};
        end
        KIND_PRESSURE: begin
          held_pressure_next        = {view[3], view[4]};
          held_air_temperature_next = {view[5], view[6]};
        end
        KIND_LIGHT: held_light_next = {view[15], view[16]};
        KIND_SOIL: begin
          held_soil_temperature_next  = {view[5], view[6]};
          held_soil_water_next        = {view[3], view[4]};
          held_soil_conductivity_next = {view[7], view[8]};
          held_salt_next              = {view[7], view[8][7:1]};
        end
        KIND_PH: held_ph_next = view[4];
        default: ;
      endcase
    end
  end

  // only the leading positions are ever read back, later bytes are counted only
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < KEPT_BYTES; i++) begin
        if (byte_count == CW'(i)) begin
          frame_buffer[i] <= rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count             <= '0;
      held_co2               <= '0;
      held_humidity          <= '0;
      held_pressure          <= '0;
      held_air_temperature   <= '0;
      held_light             <= '0;
      held_soil_temperature  <= '0;
      held_soil_water        <= '0;
      held_soil_conductivity <= '0;
      held_salt              <= '0;
      held_ph                <= '0;
    end else if (fire) begin
      byte_count             <= count_next;
      held_co2               <= held_co2_next;
      held_humidity          <= held_humidity_next;
      held_pressure          <= held_pressure_next;
      held_air_temperature   <= held_air_temperature_next;
      held_light             <= held_light_next;
      held_soil_temperature  <= held_soil_temperature_next;
      held_soil_water        <= held_soil_water_next;
      held_soil_conductivity <= held_soil_conductivity_next;
      held_salt              <= held_salt_next;
      held_ph                <= held_ph_next;
    end
  end

  always_comb begin
    result.frame_kind              = kind;
    result.co2_level               = held_co2_next;
    result.air_humidity_value      = held_humidity_next;
    result.air_pressure_value      = held_pressure_next;
    result.air_temperature_value   = held_air_temperature_next;
    result.light_level             = held_light_next;
    result.soil_temperature_value  = held_soil_temperature_next;
    result.soil_water_value        = held_soil_water_next;
    result.soil_conductivity_value = held_soil_conductivity_next;
    result.soil_salt_value         = held_salt_next;
    result.ph_value                = held_ph_next;
  end

  assign status.hit      = match;
  assign status.cnt_zero = (byte_count == '0);

endmodule

@@ rtl/core/srfd_out_reg.sv @@
// result register that drives the output channel
// depends on srfd_pkg and srfd_result_if
module srfd_out_reg import srfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  srfd_result_t         data,
  output logic                 can_load,
  srfd_result_if.source        res
);

  logic         out_valid;
  srfd_result_t out_data;

  assign can_load = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= data;
    end
  end

  assign res.valid                   = out_valid;
  assign res.frame_kind              = out_data.frame_kind;
  assign res.co2_level               = out_data.co2_level;
  assign res.air_humidity_value      = out_data.air_humidity_value;
  assign res.air_pressure_value      = out_data.air_pressure_value;
  assign res.air_temperature_value   = out_data.air_temperature_value;
  assign res.light_level             = out_data.light_level;
  assign res.soil_temperature_value  = out_data.soil_temperature_value;
  assign res.soil_water_value        = out_data.soil_water_value;
  assign res.soil_conductivity_value = out_data.soil_conductivity_value;
  assign res.soil_salt_value         = out_data.soil_salt_value;
  assign res.ph_value                = out_data.ph_value;

endmodule

@@ rtl/core/sensor_response_frame_decoder.sv @@
// top level of the sensor response frame decoder: input register, length registers
// depends on srfd_pkg, srfd_if, srfd_frame_parser and srfd_out_reg
//
// rx carries one received serial byte per word; res carries one decoded result
// per completed frame: the frame kind and every held reading, updated or not.
// bytes that do not complete a frame produce no result word.
// the five frame length registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, not enforced by the block;
// an index beyond the list is ignored. a taken byte sits in the input register and
// is decoded from there; a completed frame's result is loaded into the result
// register. one byte is taken every cycle unless a completing byte waits for the
// result register; the only loop is the byte count and held readings, updated per byte.
// when res stalls with a result waiting, bytes that complete no frame still
// flow through; a byte that completes a frame waits in the input register
// until the result register frees, and rx.ready drops behind it.
// reset clears the byte count, held readings, valid flags and restores the
// default frame lengths; the frame store itself needs no clearing.
module sensor_response_frame_decoder import srfd_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  srfd_byte_if.sink            rx,
  srfd_result_if.source        res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         advance;
  logic         out_free;
  srfd_cfg_t    cfg;
  srfd_result_t result;
  srfd_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.co2_len      <= CO2_LEN_RST;
      cfg.pressure_len <= PRESSURE_LEN_RST;
      cfg.light_len    <= LIGHT_LEN_RST;
      cfg.soil_len     <= SOIL_LEN_RST;
      cfg.ph_len       <= PH_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CO2_LEN:      cfg.co2_len      <= cfg_data;
        CFG_PRESSURE_LEN: cfg.pressure_len <= cfg_data;
        CFG_LIGHT_LEN:    cfg.light_len    <= cfg_data;
        CFG_SOIL_LEN:     cfg.soil_len     <= cfg_data;
        CFG_PH_LEN:       cfg.ph_len       <= cfg_data;
        default: ;
      endcase
    end
  end

  // a byte with no result never needs the result register
  assign advance  = in_valid && (!status.hit || out_free);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  srfd_frame_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .result  (result),
    .status  (status)
  );

  srfd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && status.hit),
    .data     (result),
    .can_load (out_free),
    .res      (res)
  );

  a_hit_shows_result: assert property (@(posedge clk) disable iff (rst)
    (advance && status.hit) |=> res.valid)
    else $error("completed frame did not reach the result register");

  a_hit_clears_count: assert property (@(posedge clk) disable iff (rst)
    (advance && status.hit) |=> status.cnt_zero)
    else $error("byte count not cleared after a completed frame");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> (in_valid && status.hit && res.valid && !res.ready))
    else $error("input stalled without a blocked result");

endmodule
